/* rtl/flb_pkg.sv */
// Shared types and constants for the FIFO line buffer.
// Holds the fixed field widths, item layout, result kinds and the
// command and status structs between the controller and the datapath.
package flb_pkg;

	localparam int ADDR_BITS  = 48;
	localparam int LINE_BYTES = 64;
	localparam int WORD_BYTES = 8;
	localparam int DATA_BITS  = 64;
	localparam int WORDS      = LINE_BYTES / WORD_BYTES;
	localparam int WIDX_BITS  = 3;
	localparam int BOFF_BITS  = $clog2(WORD_BYTES);
	localparam int OFF_BITS   = $clog2(LINE_BYTES);
	localparam int TAG_BITS   = ADDR_BITS - OFF_BITS;
	localparam int NBYTE_BITS = 4;
	localparam int CNT_BITS   = 32;
	localparam int KIND_BITS  = 2;

	// Input item layout in tdata, lowest field first.
	localparam int IN_ADDR_LSB  = 0;
	localparam int IN_BYTES_LSB = IN_ADDR_LSB + ADDR_BITS;
	localparam int IN_WORD_LSB  = IN_BYTES_LSB + NBYTE_BITS;
	localparam int IN_IDX_LSB   = IN_WORD_LSB + DATA_BITS;
	localparam int IN_USED_BITS = IN_IDX_LSB + WIDX_BITS;
	localparam int IN_TDATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

	// Result item layout in tdata, lowest field first.
	localparam int OUT_TDATA_BITS = DATA_BITS + ADDR_BITS + 2 * CNT_BITS;

	typedef logic [KIND_BITS-1:0] kind_t;
	localparam kind_t KIND_DATA = 2'd0;
	localparam kind_t KIND_FILL = 2'd1;
	localparam kind_t KIND_BUSY = 2'd2;

	localparam logic MODE_REQ  = 1'b0;
	localparam logic MODE_FILL = 1'b1;

	typedef struct packed {
		logic  load_in;
		logic  write_word;
		logic  insert_line;
		logic  cnt_hit;
		logic  cnt_miss;
		logic  set_pending;
		logic  gather_hit;
		logic  gather_fill;
		logic  rd_en;
		logic  load_out;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic hit;
		logic last;
	} sts_t;

endpackage

/* rtl/flb_ctrl.sv */
// Controller state machine of the FIFO line buffer.
// Sequences lookup, line memory read and result hand-off; tracks the
// outstanding miss. Depends on flb_pkg.
module flb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	output logic          m_valid,
	input  logic          m_ready,
	input  flb_pkg::sts_t sts,
	output flb_pkg::cmd_t cmd
);
	import flb_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_READ, ST_SEND} state_t;

	state_t state_q, state_d;
	logic   waiting_q, waiting_d;
	kind_t  kind_q, kind_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;

	assign s_ready  = (state_q == ST_IDLE);
	assign m_valid  = out_valid_q;
	assign out_free = !out_valid_q || m_ready;

	always_comb begin
		cmd         = '0;
		cmd.kind    = kind_q;
		state_d     = state_q;
		waiting_d   = waiting_q;
		kind_d      = kind_q;
		out_valid_d = out_valid_q && !m_ready;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (sts.mode == MODE_REQ) begin
					if (waiting_q) begin
						kind_d  = KIND_BUSY;
						state_d = ST_SEND;
					end else if (sts.hit) begin
						cmd.cnt_hit    = 1'b1;
						cmd.gather_hit = 1'b1;
						kind_d         = KIND_DATA;
						state_d        = ST_READ;
					end else begin
						cmd.cnt_miss    = 1'b1;
						cmd.set_pending = 1'b1;
						waiting_d       = 1'b1;
						kind_d          = KIND_FILL;
						state_d         = ST_SEND;
					end
				end else if (!waiting_q) begin
					state_d = ST_IDLE;
				end else begin
					cmd.write_word = 1'b1;
					if (sts.last) begin
						cmd.insert_line = 1'b1;
						cmd.gather_fill = 1'b1;
						waiting_d       = 1'b0;
						kind_d          = KIND_DATA;
						state_d         = ST_READ;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_SEND;
			end
			ST_SEND: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			waiting_q   <= 1'b0;
			kind_q      <= KIND_DATA;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			waiting_q   <= waiting_d;
			kind_q      <= kind_d;
			out_valid_q <= out_valid_d;
		end
	end

	// A held result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_ready))
		else $error("result register overwritten while stalled");

	// A line is only inserted while a miss is outstanding.
	a_insert_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert_line |-> waiting_q)
		else $error("line inserted without an outstanding miss");

	// A miss always leaves the block waiting for its fill.
	a_miss_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_miss |=> waiting_q)
		else $error("miss did not start a fill wait");

endmodule

/* rtl/flb_dpath.sv */
// Datapath of the FIFO line buffer: item register, tag array, line word
// memory, counters, byte gather and result register.
// Driven by flb_ctrl commands; depends on flb_pkg.
module flb_dpath #(
	parameter int ENTRIES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [flb_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	input  flb_pkg::cmd_t                       cmd,
	output flb_pkg::sts_t                       sts,
	output logic [flb_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
	output logic [flb_pkg::KIND_BITS-1:0]       m_tuser
);
	import flb_pkg::*;

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int DEPTH  = ENTRIES * WORDS;
	localparam int MEM_AW = $clog2(DEPTH);

	// Accepted item.
	logic                  in_mode_q;
	logic [ADDR_BITS-1:0]  in_addr_q;
	logic [NBYTE_BITS-1:0] in_bytes_q;
	logic [DATA_BITS-1:0]  in_word_q;
	logic [WIDX_BITS-1:0]  in_idx_q;
	logic                  in_last_q;

	logic [TAG_BITS-1:0]   tags_q [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [SLOT_W-1:0]     ins_slot_q;
	logic [ADDR_BITS-1:0]  pend_addr_q;
	logic [NBYTE_BITS-1:0] pend_bytes_q;
	logic [CNT_BITS-1:0]   hits_q, misses_q;

	logic [DATA_BITS-1:0]  mem [DEPTH];
	logic [DATA_BITS-1:0]  rd0_q, rd1_q;

	logic [SLOT_W-1:0]     g_slot_q;
	logic [OFF_BITS-1:0]   g_off_q;
	logic [NBYTE_BITS-1:0] g_bytes_q;

	kind_t                 out_kind_q;
	logic [DATA_BITS-1:0]  out_data_q;
	logic [ADDR_BITS-1:0]  out_laddr_q;
	logic [CNT_BITS-1:0]   out_hits_q, out_misses_q;

	logic [ENTRIES-1:0]    hit_vec;
	logic [SLOT_W-1:0]     hit_slot;
	logic [TAG_BITS-1:0]   in_tag;
	logic [WIDX_BITS-1:0]  g_word;
	logic [WIDX_BITS-1:0]  g_word_nx;
	logic [DATA_BITS-1:0]  hi_word;
	logic [2*DATA_BITS-1:0] pair;
	logic [DATA_BITS-1:0]  shifted;
	logic [NBYTE_BITS-1:0] nbytes;
	logic [DATA_BITS-1:0]  gathered;

	assign in_tag = in_addr_q[ADDR_BITS-1:OFF_BITS];

	always_comb begin
		hit_slot = '0;
		for (int s = 0; s < ENTRIES; s++) begin
			hit_vec[s] = valid_q[s] && (tags_q[s] == in_tag);
			if (hit_vec[s]) begin
				hit_slot = hit_slot | SLOT_W'(s);
			end
		end
	end

	assign sts.mode = in_mode_q;
	assign sts.hit  = |hit_vec;
	assign sts.last = in_last_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_mode_q  <= s_tuser;
			in_addr_q  <= s_tdata[IN_ADDR_LSB +: ADDR_BITS];
			in_bytes_q <= s_tdata[IN_BYTES_LSB +: NBYTE_BITS];
			in_word_q  <= s_tdata[IN_WORD_LSB +: DATA_BITS];
			in_idx_q   <= s_tdata[IN_IDX_LSB +: WIDX_BITS];
			in_last_q  <= s_tlast;
		end
		if (cmd.insert_line) begin
			tags_q[ins_slot_q] <= pend_addr_q[ADDR_BITS-1:OFF_BITS];
		end
		if (cmd.gather_hit) begin
			g_slot_q  <= hit_slot;
			g_off_q   <= in_addr_q[OFF_BITS-1:0];
			g_bytes_q <= in_bytes_q;
		end else if (cmd.gather_fill) begin
			g_slot_q  <= ins_slot_q;
			g_off_q   <= pend_addr_q[OFF_BITS-1:0];
			g_bytes_q <= pend_bytes_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			ins_slot_q   <= '0;
			pend_addr_q  <= '0;
			pend_bytes_q <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
		end else begin
			if (cmd.insert_line) begin
				valid_q[ins_slot_q] <= 1'b1;
				ins_slot_q <= (ins_slot_q == SLOT_W'(ENTRIES - 1)) ? '0
					: ins_slot_q + 1'b1;
			end
			if (cmd.set_pending) begin
				pend_addr_q  <= in_addr_q;
				pend_bytes_q <= in_bytes_q;
			end
			if (cmd.cnt_hit && (hits_q != '1)) begin
				hits_q <= hits_q + 1'b1;
			end
			if (cmd.cnt_miss && (misses_q != '1)) begin
				misses_q <= misses_q + 1'b1;
			end
		end
	end

	// Line word memory: one write port, two registered read ports. The
	// second port fetches the following word for items that straddle words.
	assign g_word    = g_off_q[OFF_BITS-1:BOFF_BITS];
	assign g_word_nx = g_word + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.write_word && (32'(in_idx_q) < WORDS)) begin
			mem[MEM_AW'({ins_slot_q, in_idx_q})] <= in_word_q;
		end
		if (cmd.rd_en) begin
			rd0_q <= mem[MEM_AW'({g_slot_q, g_word})];
			rd1_q <= mem[MEM_AW'({g_slot_q, g_word_nx})];
		end
	end

	// Bytes beyond the line end read as zero.
	assign hi_word = (32'(g_word) == WORDS - 1) ? '0 : rd1_q;
	assign pair    = {hi_word, rd0_q};
	assign shifted = DATA_BITS'(pair >> {g_off_q[BOFF_BITS-1:0], 3'b000});
	assign nbytes  = (g_bytes_q > NBYTE_BITS'(WORD_BYTES)) ? NBYTE_BITS'(WORD_BYTES)
		: g_bytes_q;

	always_comb begin
		for (int i = 0; i < WORD_BYTES; i++) begin
			gathered[i*8 +: 8] = (NBYTE_BITS'(i) < nbytes) ? shifted[i*8 +: 8] : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_kind_q   <= cmd.kind;
			out_data_q   <= (cmd.kind == KIND_DATA) ? gathered : '0;
			out_laddr_q  <= (cmd.kind == KIND_FILL) ? {in_tag, {OFF_BITS{1'b0}}} : '0;
			out_hits_q   <= hits_q;
			out_misses_q <= misses_q;
		end
	end

	assign m_tdata = {out_misses_q, out_hits_q, out_laddr_q, out_data_q};
	assign m_tuser = out_kind_q;

	// A line never sits in two entries, so at most one entry matches.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("line present in more than one entry");

endmodule

/* rtl/fifo_line_buffer_unit.sv */
// Top level of the FIFO line buffer: a fully associative buffer of whole
// lines with FIFO replacement and one outstanding miss.
// Instantiates flb_ctrl and flb_dpath; depends on flb_pkg.
//
//  channel  dir  tdata fields (low to high)                      tuser   tlast
//  s_axis   in   req_addr, req_bytes, fill_word, fill_index     mode    fill_last
//  m_axis   out  read_data, fill_line_addr, hit_total, miss_total kind   -
//
// One item at a time: an accepted item goes to the lookup state; a hit or a
// last fill beat then reads the line word memory in the read state, and every
// result passes the send state, which waits while an untaken result is held.
// A fill beat that is not last or that arrives with no miss open returns to
// idle from the lookup state. Results sit in an output register, so a stalled
// m_axis side does not hold up the next item until a second result is ready.
// Reset clears the valid bits, counters, FIFO pointer and miss state at once.
module fifo_line_buffer_unit #(
	parameter int ENTRIES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// req_addr[47:0], req_bytes[51:48], fill_word[115:52], fill_index[118:116]
	input  logic [flb_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	// mode
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// read_data[63:0], fill_line_addr[111:64], hit_total[143:112],
	// miss_total[175:144]
	output logic [flb_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
	// kind
	output logic [flb_pkg::KIND_BITS-1:0]       m_axis_tuser
);
	import flb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	flb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	flb_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_axis_tdata),
		.s_tuser (s_axis_tuser),
		.s_tlast (s_axis_tlast),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_axis_tdata),
		.m_tuser (m_axis_tuser)
	);

endmodule
